// ===== sv/ngll_pkg.sv =====
package ngll_pkg;

	localparam int LAT_W  = 30;
	localparam int LON_W  = 30;
	localparam int STAT_W = 2;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_W       = 8'h57;

	localparam longint unsigned SCALED_MAX = 64'd999999999;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_CHECKSUM  = 2'd1;
	localparam logic [STAT_W-1:0] ST_TYPE      = 2'd2;
	localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd3;

	// token numbers as counted after each token start
	localparam logic [2:0] TOK_LAT  = 3'd2;
	localparam logic [2:0] TOK_NS   = 3'd3;
	localparam logic [2:0] TOK_LON  = 3'd4;
	localparam logic [2:0] TOK_EW   = 3'd5;
	localparam logic [2:0] TOK_SAT  = 3'd7;

	// token length: zero, one, more than one
	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_ONE  = 2'd1;
	localparam logic [1:0] LEN_MANY = 2'd2;

	localparam logic [2:0] TYPE_LEN = 3'd5;
	localparam logic [2:0] DPOS_END = 3'd6;

	typedef struct packed {
		logic [7:0] rx_byte;
	} ngll_byte_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LAT_W-1:0]  latitude_scaled;
		logic              is_north;
		logic [LON_W-1:0]  longitude_scaled;
		logic              is_west;
	} ngll_result_t;

	// position fields of the line so far, with the current token closed
	typedef struct packed {
		logic             tokens_ok;
		logic             lat_ok;
		logic             lon_ok;
		logic             north;
		logic             west;
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
	} ngll_fld_t;

	function automatic longint unsigned pow10(input int n);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < n; i++)
			r = r * 10;
		return r;
	endfunction

	function automatic logic [7:0] type_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h47;
			3'd1: c = 8'h50;
			3'd2: c = 8'h47;
			3'd3: c = 8'h4C;
			3'd4: c = 8'h4C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// bit 4 set when the character is a hex digit of either case
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		else
			r = 5'd0;
		return r;
	endfunction

endpackage

// ===== sv/ngll_stream_if.sv =====
interface ngll_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ngll_field.sv =====
module ngll_field import ngll_pkg::*; #(
	parameter int FRACTION_DIGITS = 4,
	parameter int INTEGER_DIGITS  = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output ngll_fld_t  fld
);

	localparam int SC_W  = $clog2(pow10(INTEGER_DIGITS + FRACTION_DIGITS));
	localparam int T_W   = SC_W + 4;
	localparam int DIG_W = $clog2(FRACTION_DIGITS + 1);
	localparam logic [T_W-1:0] INT_WEIGHT = T_W'(pow10(FRACTION_DIGITS));
	localparam logic [T_W-1:0] INT_LIMIT  = T_W'(pow10(INTEGER_DIGITS + FRACTION_DIGITS));
	localparam logic [DIG_W-1:0] DIG_MAX  = DIG_W'(FRACTION_DIGITS);

	logic [2:0]       fnum_q, fnum_d;
	logic [1:0]       len_q, len_d;
	logic             tok_n_q, tok_n_d, tok_w_q, tok_w_d;
	logic [SC_W-1:0]  scaled_q, scaled_d;
	logic [DIG_W-1:0] digits_q, digits_d;
	logic             frac_q, frac_d, stop_q, stop_d, bad_q, bad_d, digit_q, digit_d;
	logic [LAT_W-1:0] lat_q, lat_n;
	logic [LON_W-1:0] lon_q, lon_n;
	logic             lat_ok_q, lat_ok_n, lon_ok_q, lon_ok_n;
	logic             north_q, north_n, west_q, west_n;

	logic [SC_W-1:0] frac_weight [FRACTION_DIGITS+1];

	for (genvar k = 0; k <= FRACTION_DIGITS; k++) begin : g_weight
		if (k < FRACTION_DIGITS) begin : g_live
			assign frac_weight[k] = SC_W'(pow10(FRACTION_DIGITS - 1 - k));
		end else begin : g_pad
			assign frac_weight[k] = '0;
		end
	end

	logic            is_nl, is_comma, is_digit, ended, num_ok;
	logic [3:0]      dval;
	logic [T_W-1:0]  int_next;
	logic [SC_W-1:0] frac_add;

	assign is_nl    = (rx_byte == CH_NEWLINE);
	assign is_comma = (rx_byte == CH_COMMA);
	assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
	assign dval     = rx_byte[3:0];
	assign ended    = (is_comma || is_nl) && (len_q != LEN_NONE);
	assign num_ok   = digit_q && !bad_q && (64'(scaled_q) <= SCALED_MAX);

	// close the current token on comma or newline
	always_comb begin
		lat_n    = lat_q;
		lon_n    = lon_q;
		lat_ok_n = lat_ok_q;
		lon_ok_n = lon_ok_q;
		north_n  = north_q;
		west_n   = west_q;
		if (ended) begin
			case (fnum_q)
				TOK_LAT: begin
					if (num_ok) begin
						lat_n    = LAT_W'(scaled_q);
						lat_ok_n = 1'b1;
					end
				end
				TOK_NS: begin
					if (len_q == LEN_ONE && tok_n_q)
						north_n = 1'b1;
				end
				TOK_LON: begin
					if (num_ok) begin
						lon_n    = LON_W'(scaled_q);
						lon_ok_n = 1'b1;
					end
				end
				TOK_EW: begin
					if (len_q == LEN_ONE && tok_w_q)
						west_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign fld.tokens_ok = (fnum_q >= TOK_EW);
	assign fld.lat_ok    = lat_ok_n;
	assign fld.lon_ok    = lon_ok_n;
	assign fld.north     = north_n;
	assign fld.west      = west_n;
	assign fld.lat       = lat_n;
	assign fld.lon       = lon_n;

	// token character: number prefix scan, kept as value times 10^FRACTION_DIGITS
	always_comb begin
		fnum_d   = fnum_q;
		len_d    = len_q;
		tok_n_d  = tok_n_q;
		tok_w_d  = tok_w_q;
		scaled_d = scaled_q;
		digits_d = digits_q;
		frac_d   = frac_q;
		stop_d   = stop_q;
		bad_d    = bad_q;
		digit_d  = digit_q;
		int_next = '0;
		frac_add = '0;
		if (is_comma) begin
			len_d = LEN_NONE;
		end else if (!is_nl) begin
			if (len_q == LEN_NONE) begin
				fnum_d   = (fnum_q == TOK_SAT) ? TOK_SAT : 3'(fnum_q + 3'd1);
				tok_n_d  = (rx_byte == CH_N);
				tok_w_d  = (rx_byte == CH_W);
				scaled_d = '0;
				digits_d = '0;
				frac_d   = 1'b0;
				stop_d   = 1'b0;
				bad_d    = 1'b0;
				digit_d  = 1'b0;
			end
			len_d = (len_q == LEN_NONE) ? LEN_ONE : LEN_MANY;
			int_next = T_W'(scaled_d) * T_W'(10) + T_W'(dval) * INT_WEIGHT;
			frac_add = SC_W'(SC_W'(dval) * frac_weight[digits_d]);
			if (!stop_d) begin
				if (is_digit) begin
					digit_d = 1'b1;
					if (frac_d) begin
						if (digits_d < DIG_MAX) begin
							scaled_d = SC_W'(scaled_d + frac_add);
							digits_d = DIG_W'(digits_d + 1'b1);
						end
					end else if (!bad_d) begin
						if (int_next >= INT_LIMIT) begin
							bad_d    = 1'b1;
							scaled_d = '0;
						end else begin
							scaled_d = SC_W'(int_next);
						end
					end
				end else if (rx_byte == CH_DOT && !frac_d) begin
					frac_d = 1'b1;
				end else begin
					stop_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnum_q   <= '0;
			len_q    <= LEN_NONE;
			tok_n_q  <= 1'b0;
			tok_w_q  <= 1'b0;
			scaled_q <= '0;
			digits_q <= '0;
			frac_q   <= 1'b0;
			stop_q   <= 1'b0;
			bad_q    <= 1'b0;
			digit_q  <= 1'b0;
			lat_q    <= '0;
			lon_q    <= '0;
			lat_ok_q <= 1'b0;
			lon_ok_q <= 1'b0;
			north_q  <= 1'b0;
			west_q   <= 1'b0;
		end else if (step) begin
			if (is_nl) begin
				// line end: start the next line afresh
				fnum_q   <= '0;
				len_q    <= LEN_NONE;
				tok_n_q  <= 1'b0;
				tok_w_q  <= 1'b0;
				scaled_q <= '0;
				digits_q <= '0;
				frac_q   <= 1'b0;
				stop_q   <= 1'b0;
				bad_q    <= 1'b0;
				digit_q  <= 1'b0;
				lat_q    <= '0;
				lon_q    <= '0;
				lat_ok_q <= 1'b0;
				lon_ok_q <= 1'b0;
				north_q  <= 1'b0;
				west_q   <= 1'b0;
			end else begin
				fnum_q   <= fnum_d;
				len_q    <= len_d;
				tok_n_q  <= tok_n_d;
				tok_w_q  <= tok_w_d;
				scaled_q <= scaled_d;
				digits_q <= digits_d;
				frac_q   <= frac_d;
				stop_q   <= stop_d;
				bad_q    <= bad_d;
				digit_q  <= digit_d;
				lat_q    <= lat_n;
				lon_q    <= lon_n;
				lat_ok_q <= lat_ok_n;
				lon_ok_q <= lon_ok_n;
				north_q  <= north_n;
				west_q   <= west_n;
			end
		end
	end

endmodule

// ===== sv/nmea_gll_sentence_parser_top.sv =====
// NMEA GLL sentence parser.
// rx carries one received character per word (rx.data.rx_byte). Every
// newline that closes a non-empty line yields one word on res: status
// (0 valid, 1 checksum bad or missing, 2 not GPGLL, 3 malformed position)
// and, when status is 0, latitude and longitude scaled by
// 10^FRACTION_DIGITS with the north and west flags; otherwise those are 0.
// An empty line yields nothing; any other character yields nothing.
// Throughput: one character per cycle while res takes results. A character
// is taken into the input register and worked on in the next cycle by the
// checksum, type and field logic; a newline's result word is loaded into
// the output register as the newline leaves the input register. When res
// stalls the result is held; rx keeps taking characters until a newline
// that closes a non-empty line reaches the input register, which then
// waits for the output register to empty.
// Reset clears the line state: the first character after reset starts a
// new line, and no result is pending.
module nmea_gll_sentence_parser_top import ngll_pkg::*; #(
	parameter int FRACTION_DIGITS = 4,
	parameter int INTEGER_DIGITS  = 5
) (
	input logic          clk,
	input logic          arst_n,
	ngll_stream_if.sink   rx,
	ngll_stream_if.source res
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         adv, emit, out_free, is_nl;

	logic [2:0]   idx_q;
	logic [7:0]   xor_q;
	logic         star_q;
	logic [7:0]   given_q;
	logic [1:0]   hex_cnt_q;
	logic [2:0]   dpos_q;
	logic         tmatch_q, smatch_q;

	logic         res_valid_q;
	ngll_result_t res_q;
	ngll_fld_t    fld;

	logic [4:0]   hex;
	logic         type_ok;
	logic [STAT_W-1:0] status;

	assign is_nl    = (byte_s1 == CH_NEWLINE);
	assign emit     = is_nl && (idx_q != 3'd0);
	assign out_free = !res_valid_q || res.ready;
	assign adv      = valid_s1 && (out_free || !emit);
	assign rx.ready = !valid_s1 || adv;

	ngll_field #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_DIGITS (INTEGER_DIGITS)
	) u_field (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.rx_byte(byte_s1),
		.fld    (fld)
	);

	assign hex = hex_nibble(byte_s1);

	always_comb begin
		type_ok = (dpos_q != 3'd0) ? (dpos_q == DPOS_END && tmatch_q)
		                           : (idx_q >= TYPE_LEN && smatch_q);
		if (!star_q || hex_cnt_q != 2'd2 || given_q != xor_q)
			status = ST_CHECKSUM;
		else if (!type_ok)
			status = ST_TYPE;
		else if (!fld.tokens_ok || !fld.lat_ok || !fld.lon_ok)
			status = ST_MALFORMED;
		else
			status = ST_OK;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.data.rx_byte;
	end

	// checksum and sentence type
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			xor_q     <= '0;
			star_q    <= 1'b0;
			given_q   <= '0;
			hex_cnt_q <= '0;
			dpos_q    <= '0;
			tmatch_q  <= 1'b1;
			smatch_q  <= 1'b1;
		end else if (adv) begin
			if (is_nl) begin
				idx_q     <= '0;
				xor_q     <= '0;
				star_q    <= 1'b0;
				given_q   <= '0;
				hex_cnt_q <= '0;
				dpos_q    <= '0;
				tmatch_q  <= 1'b1;
				smatch_q  <= 1'b1;
			end else begin
				if (!star_q) begin
					if (byte_s1 == CH_STAR)
						star_q <= 1'b1;
					else if (idx_q != 3'd0)
						xor_q <= xor_q ^ byte_s1;
				end else if (hex_cnt_q < 2'd2) begin
					if (hex[4]) begin
						given_q   <= {given_q[3:0], hex[3:0]};
						hex_cnt_q <= 2'(hex_cnt_q + 2'd1);
					end else begin
						hex_cnt_q <= 2'd3;
					end
				end
				if (dpos_q == 3'd0) begin
					if (byte_s1 == CH_DOLLAR) begin
						dpos_q   <= 3'd1;
						tmatch_q <= 1'b1;
					end
				end else if (dpos_q <= TYPE_LEN) begin
					if (byte_s1 != type_char(3'(dpos_q - 3'd1)))
						tmatch_q <= 1'b0;
					dpos_q <= 3'(dpos_q + 3'd1);
				end
				if (idx_q < TYPE_LEN && byte_s1 != type_char(idx_q))
					smatch_q <= 1'b0;
				// only the first five places matter; hold there
				if (idx_q < TYPE_LEN)
					idx_q <= 3'(idx_q + 3'd1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q.status           <= status;
			res_q.latitude_scaled  <= (status == ST_OK) ? fld.lat : '0;
			res_q.is_north         <= (status == ST_OK) && fld.north;
			res_q.longitude_scaled <= (status == ST_OK) ? fld.lon : '0;
			res_q.is_west          <= (status == ST_OK) && fld.west;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

// ===== tb/sv/ngll_tb_pkg.sv =====
`timescale 1ns / 100ps
package ngll_tb_pkg;
	import ngll_pkg::*;

	class gll_fix_checker;
		int unsigned frac_digits;
		longint unsigned int_limit;
		ngll_result_t expected_fixes[$];
		int errors;
		int fixes_seen;

		int unsigned line_len;
		logic [7:0] xor_acc;
		logic [7:0] sum_given;
		bit star_found;
		int unsigned hex_seen;
		int unsigned dollar_at;
		bit tag_ok;
		bit head_ok;
		int unsigned tok_count;
		int unsigned tok_len;
		longint unsigned num_acc;
		int unsigned num_frac;
		bit in_frac, num_stop, num_over, num_digit;
		bit tok_is_n, tok_is_w;
		logic [LAT_W-1:0] lat_val;
		logic [LON_W-1:0] lon_val;
		bit lat_good, lon_good, north_mark, west_mark;
		string gll_tag;

		function new(int unsigned fd, int unsigned id);
			frac_digits = fd;
			int_limit = 1;
			repeat (id) int_limit *= 10;
			gll_tag = "GPGLL";
			errors = 0;
			fixes_seen = 0;
			restart_line();
		endfunction

		function void restart_line();
			line_len = 0; xor_acc = 0; sum_given = 0; star_found = 0; hex_seen = 0;
			dollar_at = 0; tag_ok = 1; head_ok = 1;
			tok_count = 0; tok_len = 0;
			num_acc = 0; num_frac = 0; in_frac = 0; num_stop = 0; num_over = 0; num_digit = 0;
			tok_is_n = 0; tok_is_w = 0;
			lat_val = 0; lon_val = 0;
			lat_good = 0; lon_good = 0; north_mark = 0; west_mark = 0;
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
			if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
			if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
			return -1;
		endfunction

		function bit scaled_number(output logic [29:0] v);
			longint unsigned s;
			v = 0;
			if (!num_digit || num_over || num_frac > frac_digits) return 0;
			s = num_acc;
			for (int i = num_frac; i < frac_digits; i++) s *= 10;
			if (s > SCALED_MAX) return 0;
			v = s[29:0];
			return 1;
		endfunction

		function void close_token();
			logic [29:0] v;
			if (tok_len == 0) return;
			case (tok_count)
				TOK_LAT: if (scaled_number(v)) begin
					lat_val = v;
					lat_good = 1;
				end
				TOK_NS: if (tok_len == 1 && tok_is_n) north_mark = 1;
				TOK_LON: if (scaled_number(v)) begin
					lon_val = v;
					lon_good = 1;
				end
				TOK_EW: if (tok_len == 1 && tok_is_w) west_mark = 1;
				default: ;
			endcase
			tok_len = 0;
		endfunction

		function void token_char(logic [7:0] c);
			if (tok_len == 0) begin
				if (tok_count < TOK_SAT) tok_count++;
				num_acc = 0; num_frac = 0; in_frac = 0; num_stop = 0; num_over = 0;
				num_digit = 0;
				tok_is_n = (c == CH_N);
				tok_is_w = (c == CH_W);
			end
			if (tok_len < 15) tok_len++;
			if (num_stop) return;
			if (c >= 8'h30 && c <= 8'h39) begin
				num_digit = 1;
				if (in_frac) begin
					// drop fraction digits past the scale
					if (num_frac < frac_digits) begin
						num_acc = num_acc * 10 + (c - 8'h30);
						num_frac++;
					end
				end else if (!num_over) begin
					num_acc = num_acc * 10 + (c - 8'h30);
					if (num_acc >= int_limit) begin
						num_over = 1;
						num_acc = 0;
					end
				end
			end else if (c == CH_DOT && !in_frac) begin
				in_frac = 1;
			end else begin
				num_stop = 1;
			end
		endfunction

		function void take_char(logic [7:0] c);
			ngll_result_t r;
			bit type_good;
			int h;
			if (c == CH_NEWLINE) begin
				if (line_len == 0) begin
					restart_line();
					return;
				end
				close_token();
				type_good = (dollar_at != 0) ? (dollar_at == DPOS_END && tag_ok)
				                             : (line_len >= TYPE_LEN && head_ok);
				r = '0;
				if (!star_found || hex_seen != 2 || sum_given != xor_acc) r.status = ST_CHECKSUM;
				else if (!type_good) r.status = ST_TYPE;
				else if (tok_count < TOK_EW || !lat_good || !lon_good) r.status = ST_MALFORMED;
				else begin
					r.status = ST_OK;
					r.latitude_scaled = lat_val;
					r.is_north = north_mark;
					r.longitude_scaled = lon_val;
					r.is_west = west_mark;
				end
				expected_fixes = {expected_fixes, r};
				restart_line();
				return;
			end

			if (!star_found) begin
				if (c == CH_STAR) star_found = 1;
				else if (line_len >= 1) xor_acc ^= c;
			end else if (hex_seen < 2) begin
				h = hex_digit(c);
				if (h >= 0) begin
					sum_given = {sum_given[3:0], h[3:0]};
					hex_seen++;
				end else begin
					hex_seen = 3;
				end
			end

			if (dollar_at == 0) begin
				if (c == CH_DOLLAR) begin
					dollar_at = 1;
					tag_ok = 1;
				end
			end else if (dollar_at <= TYPE_LEN) begin
				if (c != gll_tag[dollar_at-1]) tag_ok = 0;
				dollar_at++;
			end
			if (line_len < TYPE_LEN && c != gll_tag[line_len]) head_ok = 0;

			if (c == CH_COMMA) close_token();
			else token_char(c);

			if (line_len < 127) line_len++;
		endfunction

		function void check_fix(ngll_result_t got);
			ngll_result_t want;
			if (expected_fixes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status %0d lat %0d lon %0d", $time,
					got.status, got.latitude_scaled, got.longitude_scaled);
				return;
			end
			want = expected_fixes.pop_front();
			fixes_seen++;
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
			end
			if (got.latitude_scaled !== want.latitude_scaled) begin
				errors++;
				$display("%0t: latitude expected %0d, got %0d", $time,
					want.latitude_scaled, got.latitude_scaled);
			end
			if (got.is_north !== want.is_north) begin
				errors++;
				$display("%0t: north expected %0d, got %0d", $time, want.is_north, got.is_north);
			end
			if (got.longitude_scaled !== want.longitude_scaled) begin
				errors++;
				$display("%0t: longitude expected %0d, got %0d", $time,
					want.longitude_scaled, got.longitude_scaled);
			end
			if (got.is_west !== want.is_west) begin
				errors++;
				$display("%0t: west expected %0d, got %0d", $time, want.is_west, got.is_west);
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/nmea_gll_sentence_parser_top_test.sv =====
`timescale 1ns / 100ps
module nmea_gll_sentence_parser_top_test;
	import ngll_pkg::*;
	import ngll_tb_pkg::*;

	localparam int FRACTION_DIGITS = 4;
	localparam int INTEGER_DIGITS  = 5;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_LINES    = 10;
	localparam int PHASE_LINES     = 3;
	localparam int HOLD_LINE       = 6;

	logic clk = 1'b0;
	logic arst_n;

	ngll_stream_if #(.T(ngll_byte_t))   rx();
	ngll_stream_if #(.T(ngll_result_t)) res();

	nmea_gll_sentence_parser_top #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_DIGITS(INTEGER_DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res)
	);

	gll_fix_checker fixes;
	int src_idle_pct;
	int snk_stall_pct;
	int hold_cycles;
	int cycles = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nmea_gll_sentence_parser_top_test: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			res.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			res.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rx.valid && rx.ready)
			fixes.take_char(rx.data.rx_byte);
		if (arst_n && res.valid && res.ready)
			fixes.check_fix(res.data);
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.data.rx_byte <= c;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// hold the sender until every expected position has come back
	task automatic drain();
		rx.valid <= 1'b0;
		@(negedge clk);
		while (fixes.expected_fixes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic string sealed(input string head, input bit lower = 0);
		logic [7:0] x;
		x = 0;
		for (int i = 1; i < head.len(); i++) x ^= head[i];
		return lower ? $sformatf("%s*%02x", head, x) : $sformatf("%s*%02X", head, x);
	endfunction

	function automatic string digits(input int n);
		string s;
		s = "";
		repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
		return s;
	endfunction

	function automatic string coord(input int int_n);
		string s;
		s = digits(int_n);
		if ($urandom_range(9) != 0) s = {s, ".", digits($urandom_range(6))};
		return s;
	endfunction

	function automatic string gll_head(input bit rough);
		string lat, lon, ns, ew, tail;
		lat = coord(4);
		lon = coord(5);
		ns = $urandom_range(1) ? "N" : "S";
		ew = $urandom_range(1) ? "W" : "E";
		if (rough) begin
			case ($urandom_range(9))
				0: lat = coord($urandom_range(7));
				1: lon = {coord(3), "x9"};
				2: ns = "";
				3: ew = "WW";
				4: lat = {"-", lat};
				5: ns = "n";
				6: lon = ".";
				7: lat = "99999.99999";
				8: lon = {lon, ".5"};
				default: ew = "";
			endcase
		end
		tail = $urandom_range(1) ? $sformatf(",%s,A", digits(6)) : "";
		return $sformatf("$GPGLL,%s,%s,%s,%s%s", lat, ns, lon, ew, tail);
	endfunction

	initial begin
		string line;
		int k, line_no, phase, cut;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.data = '0;
		res.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = 0;
		fixes = new(FRACTION_DIGITS, INTEGER_DIGITS);
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text({sealed("$GPGLL,4916.45,N,12311.12,W,225444,A"), "\r\n"});
		send_text({sealed("$GPGLL,0.0,S,0,E"), "\n"});
		send_text({sealed("$GPGLL,99999.9999,N,99999.99999,W"), "\n"});
		send_text("\n");
		send_text("$GPGLL,4916.45,N,12311.12,W\n");
		line = sealed("$GPGLL,1,N,2,W");
		send_text({line.substr(0, line.len() - 2), "\n"});
		send_text("$GPGLL,1,N,2,W*G1\n");
		send_text("*00,GPGLL\n");
		send_text({sealed("GPGLL,1234.5,N,54321.0,W"), "\n"});
		send_text({sealed("$GPG"), "\n"});
		send_text({sealed("$GPGLL,1234.5,N"), "\n"});
		send_text({sealed("$GPGLL,.,N,abc,W"), "\n"});
		send_text({sealed("$GPGLL,123456.7,N,100.0,E"), "\n"});
		send_text({sealed("$GPGLL,,,12.5,,,N,,7.25,W,,"), "\n"});
		send_text({sealed("$GPGLL,3859.1234,S,07702.99,W", 1), "\n"});
		send_text({sealed("$GPGGA,1,N,2,W"), "\n"});
		send_text({sealed({"$GPGLL,1.5,N,2.5,W,", digits(130)}), "\n"});
		send_text({sealed("$GPGLL,12.34.56x,N,+5,W"), "\n"});
		send_text({sealed("$GPGLL,12.5,NN,44,W"), "ZZ\n"});
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h7F);
		send_text("\n");
		drain();

		line_no = 0;
		phase = 0;
		while (line_no < RANDOM_LINES) begin
			if (line_no % PHASE_LINES == 0) begin
				drain();
				case (phase % 4)
					0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
					1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
					2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
					default: begin src_idle_pct = 26; snk_stall_pct = 26; end
				endcase
				phase++;
			end
			// fill the block while results back up
			if (line_no == HOLD_LINE && hold_cycles == 0) hold_cycles <= HOLD_OFF_CYCLES;
			line_no++;
			k = $urandom_range(99);
			if (k < 55) begin
				line = sealed(gll_head($urandom_range(3) == 0));
			end else if (k < 70) begin
				line = sealed(gll_head(0));
				line.putc($urandom_range(1, line.len() - 1), 8'($urandom_range(32, 126)));
			end else if (k < 76) begin
				line = sealed(gll_head(0));
				cut = $urandom_range(1, 3);
				line = line.substr(0, line.len() - 1 - cut);
			end else if (k < 80) begin
				line = sealed(gll_head($urandom_range(1)), 1);
			end else if (k < 84) begin
				line = gll_head(0);
				case ($urandom_range(3))
					0: line = line.substr(1, line.len() - 1);
					1: line.putc($urandom_range(1, 5), 8'($urandom_range(65, 90)));
					2: line = {"$GP,", line.substr(7, line.len() - 1)};
					default: line = {"xy", line};
				endcase
				line = sealed(line);
			end else if (k < 88) begin
				line = sealed({gll_head(0), ",", digits($urandom_range(100, 140))});
			end else if (k < 94) begin
				repeat ($urandom_range(1, 30)) send_char(8'($urandom_range(255)));
				line = "";
			end else begin
				line = $urandom_range(1) ? "" : "\r";
			end
			send_text({line, ($urandom_range(3) == 0) ? "\r\n" : "\n"});
		end
		drain();

		if (fixes.errors == 0 && fixes.expected_fixes.size() == 0)
			$display("nmea_gll_sentence_parser_top_test: done, clean");
		else
			$display("nmea_gll_sentence_parser_top_test: done, errors");
		$finish;
	end

endmodule
